// ===== src/point_in_polygon_winding_assert.svh =====
// Assertion macros for the point-in-polygon winding classifier.
`ifndef POINT_IN_POLYGON_WINDING_ASSERT_SVH
`define POINT_IN_POLYGON_WINDING_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PIPW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipw: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define PIPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipw: next-cycle implication failed");

`else

`define PIPW_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PIPW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/pipw_pkg.sv =====
// Shared constants, codes and controller/datapath structs for the winding classifier.
package pipw_pkg;

  localparam int MAX_VERTS_DEF  = 256;
  localparam int COORD_BITS_DEF = 24;

  localparam int OP_W      = 2;
  localparam int AXIS_W    = 2;
  localparam int TOL_W     = 48;
  localparam int REL_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_XY = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_XZ = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_YZ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd1;

  localparam logic [REL_W-1:0] REL_OUT = 2'd0;
  localparam logic [REL_W-1:0] REL_IN  = 2'd1;
  localparam logic [REL_W-1:0] REL_ON  = 2'd2;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 48'd1;

  typedef struct packed {
    logic load_item;
    logic do_clear;
    logic do_append;
    logic walk_init;
    logic walk_read;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_empty;
    logic            box_hit;
    logic            walk_last;
    logic            out_free;
  } dp_stat_t;

endpackage

// ===== src/pipw_in_if.sv =====
// Input item channel: operation code and one 3-D point.
interface pipw_in_if #(
  parameter int COORD_BITS = pipw_pkg::COORD_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic [pipw_pkg::OP_W-1:0]      op;
  logic signed [COORD_BITS-1:0]   x_coord;
  logic signed [COORD_BITS-1:0]   y_coord;
  logic signed [COORD_BITS-1:0]   z_coord;

  modport source (output valid, op, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, op, x_coord, y_coord, z_coord, output ready);
endinterface

// ===== src/pipw_out_if.sv =====
// Result channel: relation, status and stored vertex total.
interface pipw_out_if #(
  parameter int CNT_W = $clog2(pipw_pkg::MAX_VERTS_DEF + 1)
) ();
  logic                       valid;
  logic                       ready;
  logic [pipw_pkg::REL_W-1:0] relation;
  logic                       status;
  logic [CNT_W-1:0]           vertex_total;

  modport source (output valid, relation, status, vertex_total, input ready);
  modport sink   (input valid, relation, status, vertex_total, output ready);
endinterface

// ===== src/pipw_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface pipw_cfg_if ();
  logic                           valid;
  logic                           ready;
  logic [pipw_pkg::CFG_IDX_W-1:0] index;
  logic [pipw_pkg::TOL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pipw_dp.sv =====
// Datapath: vertex store, bounding box, edge pipeline, winding accumulator, result register.
module pipw_dp #(
  parameter int MAX_VERTS  = pipw_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = pipw_pkg::COORD_BITS_DEF,
  localparam int CNT_W     = $clog2(MAX_VERTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pipw_pkg::dp_cmd_t                 cmd,
  output pipw_pkg::dp_stat_t                stat,
  input  logic                              cfg_we,
  input  logic [pipw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pipw_pkg::TOL_W-1:0]        cfg_data,
  input  logic [pipw_pkg::OP_W-1:0]         in_op,
  input  logic signed [COORD_BITS-1:0]      in_x,
  input  logic signed [COORD_BITS-1:0]      in_y,
  input  logic signed [COORD_BITS-1:0]      in_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pipw_pkg::REL_W-1:0]        out_relation,
  output logic                              out_status,
  output logic [CNT_W-1:0]                  out_total
);
  import pipw_pkg::*;

  localparam int ADDR_W = $clog2(MAX_VERTS);
  localparam int DW     = COORD_BITS + 1;
  localparam int PW     = 2 * DW;
  localparam int CRW    = PW + 1;
  localparam int CMP_W  = (CRW > TOL_W) ? CRW : TOL_W;
  localparam int WN_W   = CNT_W + 1;
  localparam int WORD_W = 3 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [DW-1:0]         dif_t;

  // configuration registers
  logic [AXIS_W-1:0] axis_sel;
  logic [TOL_W-1:0]  tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_sel <= AXIS_XY;
      tol      <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AXIS: axis_sel <= cfg_data[AXIS_W-1:0];
        CFG_TOL:  tol      <= cfg_data;
        default: ;
      endcase
    end
  end

  // current item
  logic [OP_W-1:0] op_q;
  crd_t            pt [3];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= in_op;
      pt[0] <= in_x;
      pt[1] <= in_y;
      pt[2] <= in_z;
    end
  end

  // vertex count and store
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] last_idx;
  logic              full;
  logic              empty;
  logic              mem_we;

  assign full     = (count == CNT_W'(MAX_VERTS));
  assign empty    = (count == '0);
  assign cnt_m1   = count - CNT_W'(1);
  assign last_idx = cnt_m1[ADDR_W-1:0];
  assign mem_we   = cmd.do_append && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_clear) begin
      count <= '0;
    end else if (mem_we) begin
      count <= count + CNT_W'(1);
    end
  end

  logic [WORD_W-1:0] mem [MAX_VERTS];
  logic [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_prev_v;
  logic              rd_edge_v;

  assign rd_addr = cmd.walk_init ? last_idx : idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[ADDR_W-1:0]] <= {pt[0], pt[1], pt[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init || cmd.walk_read) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_prev_v <= 1'b0;
      rd_edge_v <= 1'b0;
    end else begin
      rd_prev_v <= cmd.walk_init;
      rd_edge_v <= cmd.walk_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      idx <= '0;
    end else if (cmd.walk_read) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  // bounding box; the first vertex after a clear sets it
  crd_t box_min [3];
  crd_t box_max [3];
  logic box_hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int k = 0; k < 3; k++) begin
        if (empty || pt[k] < box_min[k]) box_min[k] <= pt[k];
        if (empty || pt[k] > box_max[k]) box_max[k] <= pt[k];
      end
    end
  end

  always_comb begin
    box_hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (pt[k] < box_min[k] || pt[k] > box_max[k]) box_hit = 1'b0;
    end
  end

  // projection onto the selected plane
  crd_t rd_x, rd_y, rd_z;
  crd_t cu, cv, pu, pv;
  crd_t prev_u, prev_v;

  assign rd_x = rd_data[WORD_W-1 -: COORD_BITS];
  assign rd_y = rd_data[2*COORD_BITS-1 -: COORD_BITS];
  assign rd_z = rd_data[COORD_BITS-1:0];
  assign cu   = (axis_sel == AXIS_YZ) ? rd_y : rd_x;
  assign cv   = (axis_sel == AXIS_XY) ? rd_y : rd_z;
  assign pu   = (axis_sel == AXIS_YZ) ? pt[1] : pt[0];
  assign pv   = (axis_sel == AXIS_XY) ? pt[1] : pt[2];

  always_ff @(posedge clk) begin
    if (rd_prev_v || rd_edge_v) begin
      prev_u <= cu;
      prev_v <= cv;
    end
  end

  // edge stage A: differences and ordering tests
  dif_t cu_w, cv_w, pu_w, pv_w, prev_u_w, prev_v_w;
  dif_t a_dx, a_dy, a_ux, a_uy;
  logic a_valid, a_btw_u, a_btw_v, a_y0le, a_y1gt;

  assign cu_w     = {cu[COORD_BITS-1], cu};
  assign cv_w     = {cv[COORD_BITS-1], cv};
  assign pu_w     = {pu[COORD_BITS-1], pu};
  assign pv_w     = {pv[COORD_BITS-1], pv};
  assign prev_u_w = {prev_u[COORD_BITS-1], prev_u};
  assign prev_v_w = {prev_v[COORD_BITS-1], prev_v};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= rd_edge_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_edge_v) begin
      a_dx    <= pu_w - prev_u_w;
      a_dy    <= pv_w - prev_v_w;
      a_ux    <= cu_w - prev_u_w;
      a_uy    <= cv_w - prev_v_w;
      a_btw_u <= (prev_u < pu && pu < cu) || (cu < pu && pu < prev_u);
      a_btw_v <= (prev_v < pv && pv < cv) || (cv < pv && pv < prev_v);
      a_y0le  <= (prev_v <= pv);
      a_y1gt  <= (cv > pv);
    end
  end

  // edge stage B: products and dominant axis
  logic [DW-1:0]        aux, auy;
  logic signed [PW-1:0] b_p1, b_p2;
  logic                 b_valid, b_xdom, b_btw_u, b_btw_v, b_y0le, b_y1gt;

  assign aux = a_ux[DW-1] ? DW'(-a_ux) : DW'(a_ux);
  assign auy = a_uy[DW-1] ? DW'(-a_uy) : DW'(a_uy);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_p1    <= a_dx * a_uy;
      b_p2    <= a_dy * a_ux;
      b_xdom  <= (aux > auy);
      b_btw_u <= a_btw_u;
      b_btw_v <= a_btw_v;
      b_y0le  <= a_y0le;
      b_y1gt  <= a_y1gt;
    end
  end

  // edge stage C: cross product, on-line test, winding update
  logic signed [CRW-1:0] p1_w, p2_w, cr;
  logic [CRW-1:0]        mag;
  logic                  near, on_line, cr_pos, cr_neg, wind_up, wind_dn;
  logic signed [WN_W-1:0] wn;
  logic                  on_flag;
  logic                  walked;

  assign p1_w    = {b_p1[PW-1], b_p1};
  assign p2_w    = {b_p2[PW-1], b_p2};
  assign cr      = p1_w - p2_w;
  assign mag     = cr[CRW-1] ? CRW'(-cr) : CRW'(cr);
  assign near    = CMP_W'(mag) < CMP_W'(tol);
  assign on_line = near && (b_xdom ? b_btw_u : b_btw_v);
  assign cr_neg  = cr[CRW-1];
  assign cr_pos  = !cr[CRW-1] && (cr != '0);
  assign wind_up = b_y0le && b_y1gt && cr_pos;
  assign wind_dn = !b_y0le && !b_y1gt && cr_neg;

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      wn      <= '0;
      on_flag <= 1'b0;
    end else if (b_valid) begin
      if (on_line) on_flag <= 1'b1;
      if (wind_up) begin
        wn <= wn + WN_W'(1);
      end else if (wind_dn) begin
        wn <= wn - WN_W'(1);
      end
    end
  end

  logic res_st;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      walked <= 1'b0;
      res_st <= ST_DONE;
    end else begin
      if (cmd.walk_init) walked <= 1'b1;
      if (cmd.do_append && full) res_st <= ST_FULL;
    end
  end

  // result register
  logic [REL_W-1:0] rel_next;

  always_comb begin
    priority if (!walked) begin
      rel_next = REL_OUT;
    end else if (on_flag) begin
      rel_next = REL_ON;
    end else if (wn != '0) begin
      rel_next = REL_IN;
    end else begin
      rel_next = REL_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_relation <= rel_next;
      out_status   <= res_st;
      out_total    <= count;
    end
  end

  assign stat.op        = op_q;
  assign stat.is_empty  = empty;
  assign stat.box_hit   = box_hit;
  assign stat.walk_last = (idx == last_idx);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ===== src/pipw_ctrl.sv =====
// Controller: sequences clear, append and query items over the datapath.
module pipw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pipw_pkg::dp_stat_t  stat,
  output pipw_pkg::dp_cmd_t   cmd
);
  import pipw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_WALK   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // read, stage A, stage B and the accumulator update still in flight
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t     state, state_next;
  logic [1:0] drain_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_cnt <= '0;
    end else if (state == S_DRAIN) begin
      drain_cnt <= drain_cnt + 2'd1;
    end else begin
      drain_cnt <= '0;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        case (stat.op)
          OP_CLEAR:  cmd.do_clear  = 1'b1;
          OP_APPEND: cmd.do_append = 1'b1;
          OP_QUERY: begin
            // empty polygon or box miss answers outside without a walk
            if (!stat.is_empty && stat.box_hit) begin
              cmd.walk_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        cmd.walk_read = 1'b1;
        if (stat.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_cnt == DRAIN_LAST) state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/point_in_polygon_winding.sv =====
// Top level of the winding-number point-in-polygon classifier.
// Usage: item_in carries op (clear, append, query) and a signed 3-D point;
// result_out returns one transfer per item with relation, status and the
// stored vertex total; cfg writes axis_select (index 0) and on_tolerance
// (index 1) and is always ready. Write configuration only while idle.
// Items are handled one at a time. Clear, append, unknown ops and queries
// that miss the bounding box (or hit an empty polygon) go from the execute
// state to the finish state, which loads the result once the register is free.
// A query that walks the polygon first does the wrap-around read of the last
// stored vertex, then reads one vertex per cycle from the vertex memory,
// drains the pipeline (read, difference, multiply) and the accumulator
// update, and then loads the result.
// Reset clears the vertex count, the output valid and sets axis_select to
// XY and on_tolerance to 1; vertex memory and box contents are not cleared.
// When the receiver stalls, the result is held in the output register and
// the next item is still accepted; it completes its work and then waits
// until the held result has transferred.
`include "point_in_polygon_winding_assert.svh"

module point_in_polygon_winding #(
  parameter int MAX_VERTS  = pipw_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = pipw_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  pipw_cfg_if.sink       cfg,
  pipw_in_if.sink        item_in,
  pipw_out_if.source     result_out
);
  import pipw_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTS + 1);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             cfg_we;
  logic             out_valid;
  logic [REL_W-1:0] out_relation;
  logic             out_status;
  logic [CNT_W-1:0] out_total;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  pipw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pipw_dp #(
    .MAX_VERTS  (MAX_VERTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .in_op        (item_in.op),
    .in_x         (item_in.x_coord),
    .in_y         (item_in.y_coord),
    .in_z         (item_in.z_coord),
    .out_valid    (out_valid),
    .out_ready    (result_out.ready),
    .out_relation (out_relation),
    .out_status   (out_status),
    .out_total    (out_total)
  );

  assign result_out.valid        = out_valid;
  assign result_out.relation     = out_relation;
  assign result_out.status       = out_status;
  assign result_out.vertex_total = out_total;

  `PIPW_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_in.valid && item_in.ready, !item_in.ready)
  `PIPW_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.out_load, !result_out.valid || result_out.ready)
  `PIPW_ASSERT_IMPLY(a_walk_nonempty, clk, rst, cmd.walk_init || cmd.walk_read, !stat.is_empty)

endmodule

// ===== dv/tb_point_in_polygon_winding.sv =====
// Testbench for the winding-number point-in-polygon classifier: scoreboard, drivers and checks.
module tb_point_in_polygon_winding;
  timeunit 1ns;
  timeprecision 1ps;
  import pipw_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTS_DEF + 1);
  localparam int COORD_MIN = -(1 << (COORD_BITS_DEF - 1));
  localparam int COORD_MAX = (1 << (COORD_BITS_DEF - 1)) - 1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 160;

  class polygon_checker;
    typedef struct packed {
      logic [REL_W-1:0] relation;
      logic             status;
      logic [CNT_W-1:0] total;
    } answer_t;

    longint vx[MAX_VERTS_DEF];
    longint vy[MAX_VERTS_DEF];
    longint vz[MAX_VERTS_DEF];
    int unsigned stored;
    longint box_lo[3];
    longint box_hi[3];
    logic [AXIS_W-1:0] plane;
    logic [TOL_W-1:0] tolerance;
    answer_t expected_answers[$];
    int mismatches;

    function new();
      stored = 0;
      plane = AXIS_XY;
      tolerance = TOL_RESET;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] value);
      if (idx == CFG_AXIS) plane = value[AXIS_W-1:0];
      else if (idx == CFG_TOL) tolerance = value;
    endfunction

    static function bit strictly_between(longint a, longint p, longint b);
      return (a < p && p < b) || (b < p && p < a);
    endfunction

    function logic [REL_W-1:0] classify_point(longint px, longint py, longint pz);
      longint pu, pv, u0, v0, u1, v1, du, dv, cr;
      longint unsigned mag, adu, adv;
      int wn;
      int prev;
      if (stored == 0) return REL_OUT;
      if (px < box_lo[0] || px > box_hi[0] || py < box_lo[1] || py > box_hi[1] ||
          pz < box_lo[2] || pz > box_hi[2])
        return REL_OUT;
      // the spare selector falls back to XZ
      pu = (plane == AXIS_YZ) ? py : px;
      pv = (plane == AXIS_XY) ? py : pz;
      wn = 0;
      prev = stored - 1;
      for (int cur = 0; cur < stored; cur++) begin
        u0 = (plane == AXIS_YZ) ? vy[prev] : vx[prev];
        v0 = (plane == AXIS_XY) ? vy[prev] : vz[prev];
        u1 = (plane == AXIS_YZ) ? vy[cur] : vx[cur];
        v1 = (plane == AXIS_XY) ? vy[cur] : vz[cur];
        du = u1 - u0;
        dv = v1 - v0;
        cr = (pu - u0) * dv - (pv - v0) * du;
        mag = (cr < 0) ? -cr : cr;
        adu = (du < 0) ? -du : du;
        adv = (dv < 0) ? -dv : dv;
        if (mag < tolerance) begin
          if (adu > adv) begin
            if (strictly_between(u0, pu, u1)) return REL_ON;
          end else if (strictly_between(v0, pv, v1)) begin
            return REL_ON;
          end
        end
        if (v0 <= pv) begin
          if (v1 > pv && cr > 0) wn++;
        end else if (v1 <= pv && cr < 0) begin
          wn--;
        end
        prev = cur;
      end
      return (wn != 0) ? REL_IN : REL_OUT;
    endfunction

    function void predict_item(logic [OP_W-1:0] op, logic signed [COORD_BITS_DEF-1:0] x,
                               logic signed [COORD_BITS_DEF-1:0] y,
                               logic signed [COORD_BITS_DEF-1:0] z);
      answer_t ans;
      longint p[3];
      p[0] = x;
      p[1] = y;
      p[2] = z;
      ans = '0;
      case (op)
        OP_CLEAR: stored = 0;
        OP_APPEND: begin
          if (stored >= MAX_VERTS_DEF) begin
            ans.status = ST_FULL;
          end else begin
            vx[stored] = p[0];
            vy[stored] = p[1];
            vz[stored] = p[2];
            if (stored == 0) begin
              box_lo = p;
              box_hi = p;
            end else begin
              for (int k = 0; k < 3; k++) begin
                if (p[k] < box_lo[k]) box_lo[k] = p[k];
                if (p[k] > box_hi[k]) box_hi[k] = p[k];
              end
            end
            stored++;
          end
        end
        OP_QUERY: ans.relation = classify_point(p[0], p[1], p[2]);
        default: ;
      endcase
      ans.total = stored[CNT_W-1:0];
      expected_answers.push_back(ans);
    endfunction

    function void check_result(logic [REL_W-1:0] relation, logic status,
                               logic [CNT_W-1:0] total);
      answer_t want;
      if (expected_answers.size() == 0) begin
        $error("result with no pending item: relation %0d status %0d vertex_total %0d",
               relation, status, total);
        mismatches++;
        return;
      end
      want = expected_answers.pop_front();
      if (relation !== want.relation) begin
        $error("relation mismatch: expected %0d, actual %0d", want.relation, relation);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (total !== want.total) begin
        $error("vertex_total mismatch: expected %0d, actual %0d", want.total, total);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  pipw_cfg_if cfg_if ();
  pipw_in_if  item_if ();
  pipw_out_if result_if ();

  point_in_polygon_winding dut (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_if),
    .item_in    (item_if),
    .result_out (result_if)
  );

  polygon_checker sb;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_trigger = 0;
  int items_sent = 0;
  int shape_x[$];
  int shape_y[$];
  int shape_z[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off whenever the trigger moves.
  initial begin : result_sink
    int seen;
    int left;
    seen = 0;
    left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_trigger != seen) begin
        seen = hold_trigger;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        result_if.ready = 1'b0;
      end else begin
        result_if.ready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && item_if.valid && item_if.ready)
      sb.predict_item(item_if.op, item_if.x_coord, item_if.y_coord, item_if.z_coord);
    if (!rst && result_if.valid && result_if.ready)
      sb.check_result(result_if.relation, result_if.status, result_if.vertex_total);
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int rand_coord();
    return rand_between(COORD_MIN, COORD_MAX);
  endfunction

  function automatic int rand_within(int a, int b);
    return (a < b) ? rand_between(a, b) : rand_between(b, a);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic int pick_span();
    case ($urandom_range(3))
      0: return 8;
      1: return 300;
      2: return 70000;
      default: return COORD_MAX;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] OP_OP_RAND();
    return OP_W'($urandom_range(OP_UNUSED));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Offer one item and hold it until the transfer; track the stored shape for aiming queries.
  task automatic apply_item(input logic [OP_W-1:0] op, input int x, input int y, input int z);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid = 1'b0;
      @(negedge clk);
    end
    item_if.valid = 1'b1;
    item_if.op = op;
    item_if.x_coord = x[COORD_BITS_DEF-1:0];
    item_if.y_coord = y[COORD_BITS_DEF-1:0];
    item_if.z_coord = z[COORD_BITS_DEF-1:0];
    do @(posedge clk); while (!item_if.ready);
    items_sent++;
    if (op == OP_CLEAR) begin
      shape_x.delete();
      shape_y.delete();
      shape_z.delete();
    end else if (op == OP_APPEND && shape_x.size() < MAX_VERTS_DEF) begin
      shape_x.push_back(x);
      shape_y.push_back(y);
      shape_z.push_back(z);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic append_cloud(input int n, input int span);
    int cx, cy, cz;
    cx = rand_between(COORD_MIN + span, COORD_MAX - span);
    cy = rand_between(COORD_MIN + span, COORD_MAX - span);
    cz = rand_between(COORD_MIN + span, COORD_MAX - span);
    repeat (n)
      apply_item(OP_APPEND, cx + rand_between(-span, span), cy + rand_between(-span, span),
                 cz + rand_between(-span, span));
  endtask

  // Query kinds: box interior, edge midpoints, vertices, near misses, centroids, random points.
  task automatic ask_about_shape();
    int n, i, j, k, kind, x, y, z;
    n = shape_x.size();
    kind = $urandom_range(99);
    if (n == 0 || kind >= 90) begin
      x = rand_coord();
      y = rand_coord();
      z = rand_coord();
    end else begin
      i = $urandom_range(n - 1);
      j = (i + 1) % n;
      k = $urandom_range(n - 1);
      if (kind < 30) begin
        x = rand_within(shape_x[i], shape_x[k]);
        y = rand_within(shape_y[i], shape_y[k]);
        z = rand_within(shape_z[i], shape_z[k]);
      end else if (kind < 55) begin
        x = (shape_x[i] + shape_x[j]) >>> 1;
        y = (shape_y[i] + shape_y[j]) >>> 1;
        z = (shape_z[i] + shape_z[j]) >>> 1;
      end else if (kind < 65) begin
        x = shape_x[i];
        y = shape_y[i];
        z = shape_z[i];
      end else if (kind < 75) begin
        x = clamp_coord(((shape_x[i] + shape_x[j]) >>> 1) + rand_between(-1, 1));
        y = clamp_coord(((shape_y[i] + shape_y[j]) >>> 1) + rand_between(-1, 1));
        z = clamp_coord(((shape_z[i] + shape_z[j]) >>> 1) + rand_between(-1, 1));
      end else begin
        x = (shape_x[i] + shape_x[j] + shape_x[k]) / 3;
        y = (shape_y[i] + shape_y[j] + shape_y[k]) / 3;
        z = (shape_z[i] + shape_z[j] + shape_z[k]) / 3;
      end
    end
    apply_item(OP_QUERY, x, y, z);
  endtask

  task automatic one_sequence();
    int pick, n, span, m;
    pick = $urandom_range(99);
    if (pick < 65) begin
      apply_item(OP_CLEAR, rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(9) == 0) n = rand_between(1, 2);
      else if ($urandom_range(9) == 0) n = rand_between(20, 40);
      else n = rand_between(3, 10);
      append_cloud(n, pick_span());
      repeat (rand_between(4, 10)) ask_about_shape();
    end else if (pick < 80) begin
      // noise: any op, any coordinates
      repeat (rand_between(1, 4))
        apply_item(OP_OP_RAND(), rand_coord(), rand_coord(), rand_coord());
    end else if (pick < 90) begin
      // grow the current shape without a clear
      n = shape_x.size();
      m = rand_between(1, 3);
      span = pick_span();
      repeat (m) begin
        if (n == 0)
          apply_item(OP_APPEND, rand_coord(), rand_coord(), rand_coord());
        else
          apply_item(OP_APPEND, clamp_coord(shape_x[n-1] + rand_between(-span, span)),
                     clamp_coord(shape_y[n-1] + rand_between(-span, span)),
                     clamp_coord(shape_z[n-1] + rand_between(-span, span)));
      end
      repeat (rand_between(1, 3)) ask_about_shape();
    end else begin
      apply_item(OP_CLEAR, rand_coord(), rand_coord(), rand_coord());
      repeat (rand_between(1, 2)) apply_item(OP_QUERY, rand_coord(), rand_coord(), rand_coord());
      apply_item(OP_UNUSED, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Fill the store to capacity, push past it, then walk the full polygon.
  task automatic fill_to_capacity();
    apply_item(OP_CLEAR, rand_coord(), rand_coord(), rand_coord());
    append_cloud(MAX_VERTS_DEF, 70000);
    repeat (3) apply_item(OP_APPEND, rand_coord(), rand_coord(), rand_coord());
    repeat (6) ask_about_shape();
    apply_item(OP_UNUSED, rand_coord(), rand_coord(), rand_coord());
    apply_item(OP_CLEAR, rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin : stimulus
    logic [AXIS_W-1:0] axis_plan[PHASES];
    logic [TOL_W-1:0] tol_plan[PHASES];
    int idle_src[4];
    int idle_sink[4];
    int start;
    axis_plan = '{AXIS_XY, AXIS_XZ, AXIS_YZ, AXIS_SPARE, AXIS_XY, AXIS_YZ, AXIS_XZ, AXIS_XY};
    tol_plan = '{48'd1, 48'd0, 48'd1000, 48'hFFFF_FFFF_FFFF, 48'd50000, 48'd1,
                 48'd12345678, 48'd0};
    idle_src = '{0, 67, 0, 6};
    idle_sink = '{0, 0, 67, 6};
    sb = new();
    rst = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_AXIS;
    cfg_if.data = '0;
    item_if.valid = 1'b0;
    item_if.op = OP_CLEAR;
    item_if.x_coord = '0;
    item_if.y_coord = '0;
    item_if.z_coord = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(CFG_AXIS, AXIS_XY);
    write_reg(CFG_TOL, TOL_RESET);
    // directed: empty store, unknown op, extreme square, boundary and box misses
    apply_item(OP_QUERY, 0, 0, 0);
    apply_item(OP_UNUSED, COORD_MIN, COORD_MAX, -1);
    apply_item(OP_CLEAR, COORD_MAX, COORD_MIN, 0);
    apply_item(OP_APPEND, COORD_MIN, COORD_MIN, -100);
    apply_item(OP_APPEND, COORD_MAX, COORD_MIN, 100);
    apply_item(OP_APPEND, COORD_MAX, COORD_MAX, -100);
    apply_item(OP_APPEND, COORD_MIN, COORD_MAX, 100);
    apply_item(OP_QUERY, 0, 0, 0);
    apply_item(OP_QUERY, 0, COORD_MIN, 0);
    apply_item(OP_QUERY, COORD_MIN, 0, 0);
    apply_item(OP_QUERY, COORD_MAX, COORD_MAX, 0);
    apply_item(OP_QUERY, 0, 0, COORD_MAX);
    apply_item(OP_QUERY, 0, 0, COORD_MIN);
    apply_item(OP_QUERY, COORD_MAX, 0, 100);
    apply_item(OP_UNUSED, 0, 0, 0);
    apply_item(OP_CLEAR, 0, 0, 0);
    apply_item(OP_QUERY, 0, 0, 0);
    apply_item(OP_APPEND, 5, 5, 5);
    apply_item(OP_QUERY, 5, 5, 5);
    apply_item(OP_APPEND, -1, -1, -1);
    apply_item(OP_QUERY, 2, 2, 2);
    apply_item(OP_QUERY, -1, -1, -1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct = idle_src[p % 4];
      sink_stall_pct = idle_sink[p % 4];
      write_reg(CFG_AXIS, axis_plan[p]);
      write_reg(CFG_TOL, tol_plan[p]);
      if (p == 4) hold_trigger++;
      if (p == PHASES - 1) fill_to_capacity();
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) one_sequence();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== point_in_polygon_winding.f =====
+incdir+src
src/pipw_pkg.sv
src/pipw_in_if.sv
src/pipw_out_if.sv
src/pipw_cfg_if.sv
src/pipw_dp.sv
src/pipw_ctrl.sv
src/point_in_polygon_winding.sv
dv/tb_point_in_polygon_winding.sv
